>>> src/pps_pkg.sv
package pps_pkg;

  // input coordinate width (signed Q8.8)
  localparam int unsigned CoordWidth = 16;
  // light vector lanes and color lanes
  localparam int unsigned LaneW = 16;
  // width of a difference vector entering a normalizer
  localparam int unsigned VecW = ((CoordWidth > LaneW) ? CoordWidth : LaneW) + 1;
  // unit vector lanes, signed Q1.15
  localparam int unsigned UnitW = 16;
  // normalized magnitude width, leading one at bit NormW-1
  localparam int unsigned NormW = 20;
  // radicand width: sum of three squares, shifted up by NormW
  localparam int unsigned NormRadW = 3 * NormW + 2;
  localparam int unsigned SqrtSteps = NormRadW / 2;
  // quotient bits of the unit vector divide
  localparam int unsigned DivSteps = 16;
  // numerator scale of the unit vector divide
  localparam int unsigned UnitShift = 25;
  // normalizer latency in cycles
  localparam int unsigned NormLatency = SqrtSteps + DivSteps + 7;

  // scalar terms, unsigned Q.12 saturating
  localparam int unsigned TermW = 24;
  localparam logic [TermW-1:0] TermCap = '1;
  localparam logic [TermW-1:0] OneQ12 = TermW'(4096);

  localparam int unsigned ShininessMaxDef = 128;

  // configuration port
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LIGHT_MODE      = 3'd0,
    CFG_LIGHT_VECTOR    = 3'd1,
    CFG_LIGHT_RGB       = 3'd2,
    CFG_LIGHT_ALPHA     = 3'd3,
    CFG_AMBIENT_RGB     = 3'd4,
    CFG_LIGHT_INTENSITY = 3'd5,
    CFG_LIGHT_PDF       = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordWidth-1:0] hit_x;
    logic signed [CoordWidth-1:0] hit_y;
    logic signed [CoordWidth-1:0] hit_z;
    logic signed [CoordWidth-1:0] normal_x;
    logic signed [CoordWidth-1:0] normal_y;
    logic signed [CoordWidth-1:0] normal_z;
    logic signed [CoordWidth-1:0] eye_x;
    logic signed [CoordWidth-1:0] eye_y;
    logic signed [CoordWidth-1:0] eye_z;
    logic [15:0]                  diffuse_coef;
    logic [15:0]                  specular_coef;
    logic [7:0]                   shininess;
  } in_req_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
  } out_req_t;

endpackage

>>> src/pps_norm.sv
module pps_norm #(
  parameter int unsigned VecWidth = pps_pkg::VecW
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [VecWidth-1:0]        vec_i [3],
  output logic signed [pps_pkg::UnitW-1:0]  vec_o [3]
);

  localparam int unsigned NW        = pps_pkg::NormW;
  localparam int unsigned UW        = pps_pkg::UnitW;
  localparam int unsigned PosW      = $clog2(VecWidth);
  localparam int unsigned SqW       = 2 * NW;
  localparam int unsigned SumW      = SqW + 2;
  localparam int unsigned RadW      = pps_pkg::NormRadW;
  localparam int unsigned RootSteps = pps_pkg::SqrtSteps;
  localparam int unsigned LenW      = RootSteps;
  localparam int unsigned RemW      = LenW + 1;
  localparam int unsigned QW        = pps_pkg::DivSteps;
  localparam int unsigned DivPre    = pps_pkg::UnitShift - QW;

  typedef struct packed {
    logic [RadW-1:0]        rad;
    logic [RadW-1:0]        res;
    logic [2:0][NW-1:0]     mag;
    logic [2:0]             neg;
    logic                   zero;
  } root_t;

  typedef struct packed {
    logic [LenW-1:0]        len;
    logic [2:0][RemW-1:0]   rem;
    logic [2:0][QW-1:0]     quo;
    logic [2:0]             neg;
    logic                   zero;
  } div_t;

  // stage a: sign and magnitude
  logic [VecWidth-1:0] a_mag_q [3];
  logic [2:0]          a_neg_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        a_neg_q[i] <= vec_i[i][VecWidth-1];
        a_mag_q[i] <= vec_i[i][VecWidth-1] ? VecWidth'(-vec_i[i]) : VecWidth'(vec_i[i]);
      end
    end
  end

  // stage b: largest magnitude and its leading one
  logic [VecWidth-1:0] mx;
  logic [PosW-1:0]     pos_d;
  logic [VecWidth-1:0] b_mag_q [3];
  logic [2:0]          b_neg_q;
  logic [PosW-1:0]     b_pos_q;
  logic                b_zero_q;

  always_comb begin
    mx = a_mag_q[0];
    if (a_mag_q[1] > mx) mx = a_mag_q[1];
    if (a_mag_q[2] > mx) mx = a_mag_q[2];
    pos_d = '0;
    for (int b = 0; b < VecWidth; b++) begin
      if (mx[b]) pos_d = PosW'(b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_mag_q  <= a_mag_q;
      b_neg_q  <= a_neg_q;
      b_pos_q  <= pos_d;
      b_zero_q <= (mx == '0);
    end
  end

  // stage c: scale so the largest lane has its leading one at bit NW-1
  logic [VecWidth+NW-1:0] wide [3];
  logic [NW-1:0]          c_mag_q [3];
  logic [2:0]             c_neg_q;
  logic                   c_zero_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide[i] = {b_mag_q[i], {NW{1'b0}}} >> ({1'b0, b_pos_q} + (PosW + 1)'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) c_mag_q[i] <= wide[i][NW-1:0];
      c_neg_q  <= b_neg_q;
      c_zero_q <= b_zero_q;
    end
  end

  // stage d: squares
  logic [SqW-1:0] d_sq_q  [3];
  logic [NW-1:0]  d_mag_q [3];
  logic [2:0]     d_neg_q;
  logic           d_zero_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) d_sq_q[i] <= c_mag_q[i] * c_mag_q[i];
      d_mag_q  <= c_mag_q;
      d_neg_q  <= c_neg_q;
      d_zero_q <= c_zero_q;
    end
  end

  // stage e: sum of squares into the root pipeline
  root_t          rt_q [RootSteps+1];
  logic [SumW-1:0] sum_d;

  assign sum_d = SumW'(d_sq_q[0]) + SumW'(d_sq_q[1]) + SumW'(d_sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rt_q[0].rad  <= {sum_d, {NW{1'b0}}};
      rt_q[0].res  <= '0;
      for (int i = 0; i < 3; i++) rt_q[0].mag[i] <= d_mag_q[i];
      rt_q[0].neg  <= d_neg_q;
      rt_q[0].zero <= d_zero_q;
    end
  end

  // integer square root, one result bit per stage
  for (genvar k = 0; k < RootSteps; k++) begin : g_root
    localparam logic [RadW-1:0] RootBit = RadW'(1) << (2 * (RootSteps - 1 - k));
    root_t           nx;
    logic [RadW-1:0] trial;

    always_comb begin
      nx    = rt_q[k];
      trial = rt_q[k].res + RootBit;
      if (rt_q[k].rad >= trial) begin
        nx.rad = rt_q[k].rad - trial;
        nx.res = (rt_q[k].res >> 1) + RootBit;
      end else begin
        nx.res = rt_q[k].res >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) rt_q[k+1] <= nx;
    end
  end

  // stage f: set up the divide by the length
  div_t dv_q [QW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q[0].len <= rt_q[RootSteps].res[LenW-1:0];
      for (int i = 0; i < 3; i++) begin
        dv_q[0].rem[i] <= RemW'(rt_q[RootSteps].mag[i]) << DivPre;
        dv_q[0].quo[i] <= '0;
      end
      dv_q[0].neg  <= rt_q[RootSteps].neg;
      dv_q[0].zero <= rt_q[RootSteps].zero;
    end
  end

  // restoring divide, one quotient bit per stage on all three lanes
  for (genvar j = 0; j < QW; j++) begin : g_div
    div_t nx;

    always_comb begin
      logic [RemW-1:0] r2;
      nx = dv_q[j];
      for (int i = 0; i < 3; i++) begin
        r2 = {dv_q[j].rem[i][RemW-2:0], 1'b0};
        if (r2 >= RemW'(dv_q[j].len)) begin
          nx.rem[i] = r2 - RemW'(dv_q[j].len);
          nx.quo[i] = {dv_q[j].quo[i][QW-2:0], 1'b1};
        end else begin
          nx.rem[i] = r2;
          nx.quo[i] = {dv_q[j].quo[i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) dv_q[j+1] <= nx;
    end
  end

  // clamp, restore sign
  logic [UW-1:0]        qc    [3];
  logic signed [UW-1:0] vec_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = dv_q[QW].quo[i][QW-1] ? {1'b0, {(UW-1){1'b1}}} : UW'(dv_q[QW].quo[i]);
      if (dv_q[QW].zero) qc[i] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        vec_q[i] <= dv_q[QW].neg[i] ? -qc[i] : qc[i];
      end
    end
  end

  assign vec_o = vec_q;

endmodule

>>> src/phong_point_shader_core.sv
// channel  | direction | handshake           | payload
// in       | in        | in_valid_i/in_stall_o | in_req_i  (pps_pkg::in_req_t)
// out      | out       | out_valid_o/out_stall_i | out_req_o (pps_pkg::out_req_t)
// cfg      | in        | cfg_we_i            | cfg_idx_i, cfg_data_i
//
// one request enters per cycle unless a stalled result freezes the pipeline; the pipeline depth
// is set by the square root and divide of the three normalizers and one power stage per exponent bit.
// reset clears the valid line and loads the light registers with their defaults.
// a stalled result freezes the whole pipeline; in_stall_o follows out_stall_i only then.
module phong_point_shader_core #(
  parameter int unsigned SHININESS_MAX = pps_pkg::ShininessMaxDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pps_pkg::in_req_t              in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pps_pkg::out_req_t             out_req_o,
  input  logic                          cfg_we_i,
  input  logic [pps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pps_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned ExpW    = $clog2(SHININESS_MAX + 1);
  localparam int unsigned NormLat = pps_pkg::NormLatency;
  localparam int unsigned PipeLat = NormLat + ExpW + 10;
  localparam int unsigned CW      = pps_pkg::CoordWidth;
  localparam int unsigned VecW    = pps_pkg::VecW;
  localparam int unsigned UnitW   = pps_pkg::UnitW;
  localparam int unsigned LaneW   = pps_pkg::LaneW;
  localparam int unsigned TermW   = pps_pkg::TermW;
  localparam int unsigned LvW     = LaneW + 8;
  localparam int unsigned PnW     = UnitW + LvW;
  localparam int unsigned NdlW    = PnW + 2;
  localparam int unsigned TW      = NdlW + UnitW + 1;
  localparam int unsigned RvW     = TW - 30;
  localparam int unsigned PvW     = UnitW + RvW;
  localparam int unsigned VdrW    = PvW + 2;
  localparam int unsigned SumW    = TermW + 2;
  localparam int unsigned ProdW   = SumW + LaneW;

  typedef struct packed {
    logic [15:0] kd;
    logic [15:0] ks;
    logic [7:0]  sh;
  } sb_t;

  typedef struct packed {
    logic [TermW-1:0] r;
    logic [TermW-1:0] base;
    logic [TermW-1:0] diff;
    logic [TermW-1:0] ks1;
    logic [7:0]       e;
  } pw_t;

  function automatic logic [TermW-1:0] cap_term(input logic [63:0] v);
    cap_term = (v > 64'(pps_pkg::TermCap)) ? pps_pkg::TermCap : v[TermW-1:0];
  endfunction

  // light registers
  logic                    light_mode_q;
  logic [3*LaneW-1:0]      light_vector_q;
  logic [3*LaneW-1:0]      light_rgb_q;
  logic [LaneW-1:0]        light_alpha_q;
  logic [3*LaneW-1:0]      ambient_rgb_q;
  logic [15:0]             light_intensity_q;
  logic [15:0]             light_pdf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_mode_q      <= 1'b1;
      light_vector_q    <= '0;
      light_rgb_q       <= '0;
      light_alpha_q     <= 16'd4096;
      ambient_rgb_q     <= '0;
      light_intensity_q <= 16'd256;
      light_pdf_q       <= 16'd256;
    end else if (cfg_we_i) begin
      unique case (pps_pkg::cfg_idx_e'(cfg_idx_i))
        pps_pkg::CFG_LIGHT_MODE:      light_mode_q      <= cfg_data_i[0];
        pps_pkg::CFG_LIGHT_VECTOR:    light_vector_q    <= cfg_data_i[3*LaneW-1:0];
        pps_pkg::CFG_LIGHT_RGB:       light_rgb_q       <= cfg_data_i[3*LaneW-1:0];
        pps_pkg::CFG_LIGHT_ALPHA:     light_alpha_q     <= cfg_data_i[LaneW-1:0];
        pps_pkg::CFG_AMBIENT_RGB:     ambient_rgb_q     <= cfg_data_i[3*LaneW-1:0];
        pps_pkg::CFG_LIGHT_INTENSITY: light_intensity_q <= cfg_data_i[15:0];
        pps_pkg::CFG_LIGHT_PDF:       light_pdf_q       <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // global pipeline advance
  logic               adv;
  logic               accept;
  logic [PipeLat-1:0] vld_q;

  assign adv        = !(vld_q[PipeLat-1] && out_stall_i);
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PipeLat-2:0], accept};
    end
  end

  // vectors into the normalizers
  logic signed [CW-1:0]    hit [3];
  logic signed [CW-1:0]    nrm [3];
  logic signed [CW-1:0]    eye [3];
  logic signed [VecW-1:0]  nvec [3];
  logic signed [VecW-1:0]  lvec [3];
  logic signed [VecW-1:0]  vvec [3];

  always_comb begin
    hit[0] = in_req_i.hit_x;    hit[1] = in_req_i.hit_y;    hit[2] = in_req_i.hit_z;
    nrm[0] = in_req_i.normal_x; nrm[1] = in_req_i.normal_y; nrm[2] = in_req_i.normal_z;
    eye[0] = in_req_i.eye_x;    eye[1] = in_req_i.eye_y;    eye[2] = in_req_i.eye_z;
    for (int i = 0; i < 3; i++) begin
      nvec[i] = VecW'(nrm[i]);
      vvec[i] = VecW'(hit[i]) - VecW'(eye[i]);
      lvec[i] = VecW'(signed'(light_vector_q[LaneW*i +: LaneW])) - VecW'(hit[i]);
    end
  end

  logic signed [UnitW-1:0] nu_w [3];
  logic signed [UnitW-1:0] lu_w [3];
  logic signed [UnitW-1:0] vu_w [3];

  pps_norm #(.VecWidth(VecW)) u_norm_n (
    .clk_i (clk_i), .en_i (adv), .vec_i (nvec), .vec_o (nu_w)
  );
  pps_norm #(.VecWidth(VecW)) u_norm_l (
    .clk_i (clk_i), .en_i (adv), .vec_i (lvec), .vec_o (lu_w)
  );
  pps_norm #(.VecWidth(VecW)) u_norm_v (
    .clk_i (clk_i), .en_i (adv), .vec_i (vvec), .vec_o (vu_w)
  );

  // material fields travel beside the normalizers
  sb_t sb_d;
  sb_t sb_q [NormLat];

  always_comb begin
    sb_d.kd = in_req_i.diffuse_coef;
    sb_d.ks = in_req_i.specular_coef;
    sb_d.sh = (in_req_i.shininess > 8'(SHININESS_MAX)) ? 8'(SHININESS_MAX)
                                                      : in_req_i.shininess;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_q[0] <= sb_d;
      for (int k = 1; k < NormLat; k++) sb_q[k] <= sb_q[k-1];
    end
  end

  // stage 1: light vector select, n*l lanes, intensity products
  logic signed [LvW-1:0]   lv_d  [3];
  logic signed [PnW-1:0]   pn_d  [3];
  logic [31:0]             pi_p;
  logic [31:0]             ki_p;
  logic signed [UnitW-1:0] s1_nu_q [3];
  logic signed [UnitW-1:0] s1_vu_q [3];
  logic signed [LvW-1:0]   s1_lv_q [3];
  logic signed [PnW-1:0]   s1_pn_q [3];
  logic [TermW-1:0]        s1_a1_q;
  logic [TermW-1:0]        s1_ks1_q;
  logic [15:0]             s1_kd_q;
  logic [7:0]              s1_sh_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lv_d[i] = light_mode_q ? LvW'(lu_w[i])
                             : -(LvW'(signed'(light_vector_q[LaneW*i +: LaneW])) <<< 7);
      pn_d[i] = PnW'(nu_w[i]) * PnW'(lv_d[i]);
    end
    pi_p = light_pdf_q * light_intensity_q;
    ki_p = sb_q[NormLat-1].ks * light_intensity_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_nu_q  <= nu_w;
      s1_vu_q  <= vu_w;
      s1_lv_q  <= lv_d;
      s1_pn_q  <= pn_d;
      s1_a1_q  <= cap_term(64'(pi_p >> 4));
      s1_ks1_q <= cap_term(64'(ki_p >> 11));
      s1_kd_q  <= sb_q[NormLat-1].kd;
      s1_sh_q  <= sb_q[NormLat-1].sh;
    end
  end

  // stage 2: n.l and the diffuse cosine
  logic signed [NdlW-1:0]  ndl_d;
  logic [TermW+15:0]       a2_p;
  logic signed [NdlW-1:0]  s2_ndl_q;
  logic [TermW-1:0]        s2_cosd_q;
  logic [TermW-1:0]        s2_a2_q;
  logic signed [UnitW-1:0] s2_nu_q [3];
  logic signed [UnitW-1:0] s2_vu_q [3];
  logic signed [LvW-1:0]   s2_lv_q [3];
  logic [TermW-1:0]        s2_ks1_q;
  logic [7:0]              s2_sh_q;

  always_comb begin
    ndl_d = NdlW'(s1_pn_q[0]) + NdlW'(s1_pn_q[1]) + NdlW'(s1_pn_q[2]);
    a2_p  = s1_a1_q * s1_kd_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_ndl_q  <= ndl_d;
      s2_cosd_q <= (ndl_d > 0) ? cap_term(64'(ndl_d) >> 18) : '0;
      s2_a2_q   <= cap_term(64'(a2_p >> 15));
      s2_nu_q   <= s1_nu_q;
      s2_vu_q   <= s1_vu_q;
      s2_lv_q   <= s1_lv_q;
      s2_ks1_q  <= s1_ks1_q;
      s2_sh_q   <= s1_sh_q;
    end
  end

  // stage 3: 2(n.l)n and the diffuse term
  logic signed [TW-1:0]    t_d [3];
  logic [2*TermW-1:0]      df_p;
  logic signed [TW-1:0]    s3_t_q  [3];
  logic signed [UnitW-1:0] s3_vu_q [3];
  logic signed [LvW-1:0]   s3_lv_q [3];
  logic [TermW-1:0]        s3_diff_q;
  logic [TermW-1:0]        s3_ks1_q;
  logic [7:0]              s3_sh_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_d[i] = (TW'(s2_ndl_q) * TW'(s2_nu_q[i])) <<< 1;
    end
    df_p = s2_a2_q * s2_cosd_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_t_q    <= t_d;
      s3_vu_q   <= s2_vu_q;
      s3_lv_q   <= s2_lv_q;
      s3_diff_q <= cap_term(64'(df_p >> 12));
      s3_ks1_q  <= s2_ks1_q;
      s3_sh_q   <= s2_sh_q;
    end
  end

  // stage 4: reflected vector, shift truncates toward zero
  logic [TW-1:0]           tm  [3];
  logic [TW-1:0]           tq  [3];
  logic signed [RvW-1:0]   rv_d [3];
  logic signed [RvW-1:0]   s4_rv_q [3];
  logic signed [UnitW-1:0] s4_vu_q [3];
  logic [TermW-1:0]        s4_diff_q;
  logic [TermW-1:0]        s4_ks1_q;
  logic [7:0]              s4_sh_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tm[i]   = s3_t_q[i][TW-1] ? TW'(-s3_t_q[i]) : TW'(s3_t_q[i]);
      tq[i]   = tm[i] >> 30;
      rv_d[i] = s3_t_q[i][TW-1] ? RvW'(s3_lv_q[i]) + RvW'(tq[i])
                                : RvW'(s3_lv_q[i]) - RvW'(tq[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_rv_q   <= rv_d;
      s4_vu_q   <= s3_vu_q;
      s4_diff_q <= s3_diff_q;
      s4_ks1_q  <= s3_ks1_q;
      s4_sh_q   <= s3_sh_q;
    end
  end

  // stage 5: v*r lanes
  logic signed [PvW-1:0]   s5_pv_q [3];
  logic [TermW-1:0]        s5_diff_q;
  logic [TermW-1:0]        s5_ks1_q;
  logic [7:0]              s5_sh_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) s5_pv_q[i] <= PvW'(s4_vu_q[i]) * PvW'(s4_rv_q[i]);
      s5_diff_q <= s4_diff_q;
      s5_ks1_q  <= s4_ks1_q;
      s5_sh_q   <= s4_sh_q;
    end
  end

  // stage 6: v.r, the specular cosine starts the power pipeline
  logic signed [VdrW-1:0] vdr_d;
  pw_t                    pw_q [ExpW+1];

  assign vdr_d = VdrW'(s5_pv_q[0]) + VdrW'(s5_pv_q[1]) + VdrW'(s5_pv_q[2]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pw_q[0].r    <= pps_pkg::OneQ12;
      pw_q[0].base <= (vdr_d > 0) ? cap_term(64'(vdr_d) >> 18) : '0;
      pw_q[0].diff <= s5_diff_q;
      pw_q[0].ks1  <= s5_ks1_q;
      pw_q[0].e    <= s5_sh_q;
    end
  end

  // square and multiply, one exponent bit per stage
  for (genvar k = 0; k < ExpW; k++) begin : g_pow
    logic [2*TermW-1:0] r_p;
    logic [2*TermW-1:0] b_p;
    pw_t                nx;

    always_comb begin
      r_p     = pw_q[k].r * pw_q[k].base;
      b_p     = pw_q[k].base * pw_q[k].base;
      nx      = pw_q[k];
      if (pw_q[k].e[k]) nx.r = cap_term(64'(r_p >> 12));
      nx.base = cap_term(64'(b_p >> 12));
    end

    always_ff @(posedge clk_i) begin
      if (adv) pw_q[k+1] <= nx;
    end
  end

  // stage 7: specular term
  logic [2*TermW-1:0] sp_p;
  logic [TermW-1:0]   s7_spec_q;
  logic [TermW-1:0]   s7_diff_q;

  assign sp_p = pw_q[ExpW].ks1 * pw_q[ExpW].r;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_spec_q <= cap_term(64'(sp_p >> 12));
      s7_diff_q <= pw_q[ExpW].diff;
    end
  end

  // stage 8: d+s plus ambient per channel, plus one for alpha
  logic [SumW-1:0] s8_sum_q [4];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s8_sum_q[i] <= SumW'(s7_diff_q) + SumW'(s7_spec_q)
                     + SumW'(ambient_rgb_q[LaneW*i +: LaneW]);
      end
      s8_sum_q[3] <= SumW'(s7_diff_q) + SumW'(s7_spec_q) + SumW'(pps_pkg::OneQ12);
    end
  end

  // stage 9: scale by the light color
  logic [LaneW-1:0] lc [4];
  logic [ProdW-1:0] s9_prod_q [4];

  always_comb begin
    for (int i = 0; i < 3; i++) lc[i] = light_rgb_q[LaneW*i +: LaneW];
    lc[3] = light_alpha_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) s9_prod_q[i] <= s8_sum_q[i] * lc[i];
    end
  end

  // stage 10: saturate into the output register
  logic [ProdW-13:0] osh [4];
  logic [LaneW-1:0]  oc  [4];
  pps_pkg::out_req_t out_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      osh[i] = s9_prod_q[i][ProdW-1:12];
      oc[i]  = (osh[i] > (ProdW-12)'(16'hFFFF)) ? 16'hFFFF : osh[i][LaneW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.out_red   <= oc[0];
      out_q.out_green <= oc[1];
      out_q.out_blue  <= oc[2];
      out_q.out_alpha <= oc[3];
    end
  end

  assign out_valid_o = vld_q[PipeLat-1];
  assign out_req_o   = out_q;

  // input backpressure only comes from a held result
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // a frozen pipeline keeps its valid line
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("valid line moved while frozen");

  // zero exponent leaves the power at one
  a_pow_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NormLat+5+ExpW] && (pw_q[ExpW].e == '0)) |-> (pw_q[ExpW].r == pps_pkg::OneQ12))
    else $error("power of zero exponent is not one");

endmodule
